FILE: design/sao_pkg.sv
// shared types, constants and helper functions of the sample adaptive offset filter
// no dependencies; every other file of the block imports this package
package sao_pkg;

  localparam int PixelBits = 10;
  localparam int PixW      = 10;
  localparam int OffW      = 5;

  // highest usable pixel depth
  localparam logic [3:0] DepthMax = (PixelBits > 15) ? 4'd15 : 4'(PixelBits);
  localparam logic [3:0] DepthMin = 4'd8;

  // filter type codes
  localparam logic [2:0] FT_OFF     = 3'd0;
  localparam logic [2:0] FT_EO_HOR  = 3'd1;
  localparam logic [2:0] FT_EO_VER  = 3'd2;
  localparam logic [2:0] FT_EO_135  = 3'd3;
  localparam logic [2:0] FT_EO_45   = 3'd4;
  localparam logic [2:0] FT_BAND    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_FILTER_TYPE    = 3'd0;
  localparam logic [2:0] CFG_PIX_DEPTH      = 3'd1;
  localparam logic [2:0] CFG_NEIGHBOR_AVAIL = 3'd2;
  localparam logic [2:0] CFG_OFFSET_A       = 3'd3;
  localparam logic [2:0] CFG_OFFSET_B       = 3'd4;
  localparam logic [2:0] CFG_OFFSET_C       = 3'd5;
  localparam logic [2:0] CFG_OFFSET_D       = 3'd6;
  localparam logic [2:0] CFG_BAND_CODE      = 3'd7;

  // edge classes
  localparam logic [2:0] CLS_VALLEY      = 3'd0;
  localparam logic [2:0] CLS_CONCAVE     = 3'd1;
  localparam logic [2:0] CLS_FLAT        = 3'd2;
  localparam logic [2:0] CLS_CONVEX      = 3'd3;
  localparam logic [2:0] CLS_PEAK        = 3'd4;

  typedef struct packed {
    logic [PixW-1:0] center_pixel;
    logic [PixW-1:0] neighbor_a;
    logic [PixW-1:0] neighbor_b;
    logic            first_col;
    logic            last_col;
    logic            first_row;
    logic            last_row;
  } sao_in_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic            written;
  } sao_out_t;

  typedef struct packed {
    logic [2:0]             filter_type;
    logic [3:0]             pix_depth;
    logic [7:0]             neighbor_avail;
    logic signed [OffW-1:0] offset_a;
    logic signed [OffW-1:0] offset_b;
    logic signed [OffW-1:0] offset_c;
    logic signed [OffW-1:0] offset_d;
    logic [9:0]             band_code;
  } sao_cfg_t;

  localparam sao_cfg_t CfgReset = '{
    filter_type:    FT_OFF,
    pix_depth:      4'd8,
    neighbor_avail: 8'd0,
    offset_a:       5'sd0,
    offset_b:       5'sd0,
    offset_c:       5'sd0,
    offset_d:       5'sd0,
    band_code:      10'd0
  };

  // first stage result: classification
  typedef struct packed {
    logic [PixW-1:0] center;
    logic            apply;
    logic            is_band;
    logic [2:0]      cls;
    logic            band_low;
    logic [4:0]      band;
  } sao_cls_t;

  // second stage result: selected offset
  typedef struct packed {
    logic [PixW-1:0]        center;
    logic                   apply;
    logic signed [OffW-1:0] off;
  } sao_off_t;

  function automatic logic [3:0] sao_eff_depth(input logic [3:0] bd);
    logic [3:0] d;
    if (bd < DepthMin) begin
      d = DepthMin;
    end else if (bd > DepthMax) begin
      d = DepthMax;
    end else begin
      d = bd;
    end
    return d;
  endfunction

  function automatic logic [PixW-1:0] sao_max_pixel(input logic [3:0] depth);
    logic [15:0] m;
    m = (16'd1 << depth) - 16'd1;
    if (m > 16'd1023) begin
      m = 16'd1023;
    end
    return m[PixW-1:0];
  endfunction

  // neighbor availability for the diagonal directions
  function automatic logic sao_diag_ok(input logic diag45, input logic [7:0] av,
                                       input logic fc, input logic lc,
                                       input logic fr, input logic lr);
    logic ok;
    ok = 1'b1;
    if (!fr && !lr) begin
      ok = (!fc || av[2]) && (!lc || av[3]);
    end else begin
      if (fr) begin
        if (!diag45) begin
          ok = ok && (av[4] || !fc) && (av[0] ? (!lc || av[3]) : fc);
        end else begin
          ok = ok && (av[0] ? (!fc || av[2]) : lc) && (av[5] || !lc);
        end
      end
      if (lr) begin
        if (!diag45) begin
          ok = ok && (av[1] ? (!fc || av[2]) : lc) && (av[7] || !lc);
        end else begin
          ok = ok && (!fc || av[6]) && (av[1] ? (!lc || av[3]) : fc);
        end
      end
    end
    return ok;
  endfunction

  function automatic logic sao_apply(input logic [2:0] ft, input logic [7:0] av,
                                     input logic fc, input logic lc,
                                     input logic fr, input logic lr);
    logic ok;
    case (ft)
      FT_EO_HOR: ok = (!fc || av[2]) && (!lc || av[3]);
      FT_EO_VER: ok = (!fr || av[0]) && (!lr || av[1]);
      FT_EO_135: ok = sao_diag_ok(1'b0, av, fc, lc, fr, lr);
      FT_EO_45:  ok = sao_diag_ok(1'b1, av, fc, lc, fr, lr);
      FT_BAND:   ok = 1'b1;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: design/sao_classify.sv
// first pipeline stage: availability check, edge class and band index
// depends on sao_pkg
module sao_classify (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sao_pkg::sao_cfg_t  cfg_i,
  input  logic               valid_i,
  input  sao_pkg::sao_in_t   word_i,
  output logic               stall_o,
  output logic               valid_o,
  output sao_pkg::sao_cls_t  word_o,
  input  logic               stall_i
);
  import sao_pkg::*;

  logic            valid_q;
  sao_cls_t        word_d, word_q;
  logic [3:0]      depth;
  logic [PixW-1:0] band_full;
  logic            gt_a, lt_a, gt_b, lt_b;

  assign depth     = sao_eff_depth(cfg_i.pix_depth);
  assign band_full = word_i.center_pixel >> (depth - 4'd5);

  assign gt_a = word_i.center_pixel > word_i.neighbor_a;
  assign lt_a = word_i.center_pixel < word_i.neighbor_a;
  assign gt_b = word_i.center_pixel > word_i.neighbor_b;
  assign lt_b = word_i.center_pixel < word_i.neighbor_b;

  always_comb begin
    word_d.center   = word_i.center_pixel;
    word_d.apply    = sao_apply(cfg_i.filter_type, cfg_i.neighbor_avail,
                                word_i.first_col, word_i.last_col,
                                word_i.first_row, word_i.last_row);
    word_d.is_band  = (cfg_i.filter_type == FT_BAND);
    // sign sum plus two, wraps harmlessly in between
    word_d.cls      = CLS_FLAT + {2'b00, gt_a} + {2'b00, gt_b}
                      - {2'b00, lt_a} - {2'b00, lt_b};
    word_d.band_low = (band_full[PixW-1:5] == '0);
    word_d.band     = band_full[4:0];
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: design/sao_offset.sv
// second pipeline stage: offset selection for edge classes and bands
// depends on sao_pkg
module sao_offset (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sao_pkg::sao_cfg_t  cfg_i,
  input  logic               valid_i,
  input  sao_pkg::sao_cls_t  word_i,
  output logic               stall_o,
  output logic               valid_o,
  output sao_pkg::sao_off_t  word_o,
  input  logic               stall_i
);
  import sao_pkg::*;

  logic                   valid_q;
  sao_off_t               word_d, word_q;
  logic [4:0]             start1, start2;
  logic signed [OffW-1:0] off;

  assign start1 = cfg_i.band_code[4:0];
  assign start2 = start1 + cfg_i.band_code[9:5];

  always_comb begin
    off = '0;
    if (word_i.is_band) begin
      // later matches override earlier ones
      if (word_i.band_low) begin
        if (word_i.band == start1)         off = cfg_i.offset_a;
        if (word_i.band == start1 + 5'd1)  off = cfg_i.offset_b;
        if (word_i.band == start2)         off = cfg_i.offset_c;
        if (word_i.band == start2 + 5'd1)  off = cfg_i.offset_d;
      end
    end else begin
      case (word_i.cls)
        CLS_VALLEY:  off = cfg_i.offset_a;
        CLS_CONCAVE: off = cfg_i.offset_b;
        CLS_CONVEX:  off = cfg_i.offset_c;
        CLS_PEAK:    off = cfg_i.offset_d;
        default:     off = '0;
      endcase
    end
    word_d.center = word_i.center;
    word_d.apply  = word_i.apply;
    word_d.off    = off;
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: design/sao_clip.sv
// third pipeline stage: offset add, clip to the pixel range, output register
// depends on sao_pkg
module sao_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sao_pkg::sao_cfg_t  cfg_i,
  input  logic               valid_i,
  input  sao_pkg::sao_off_t  word_i,
  output logic               stall_o,
  output logic               valid_o,
  output sao_pkg::sao_out_t  word_o,
  input  logic               stall_i
);
  import sao_pkg::*;

  logic                 valid_q;
  sao_out_t             word_d, word_q;
  logic [PixW-1:0]      max_pix;
  logic signed [PixW+1:0] sum;

  assign max_pix = sao_max_pixel(sao_eff_depth(cfg_i.pix_depth));
  assign sum     = $signed({2'b00, word_i.center}) + (PixW+2)'(word_i.off);

  always_comb begin
    if (!word_i.apply) begin
      word_d.pixel_out = word_i.center;
      word_d.written   = 1'b0;
    end else begin
      word_d.written = 1'b1;
      if (sum < 0) begin
        word_d.pixel_out = '0;
      end else if (sum > $signed({2'b00, max_pix})) begin
        word_d.pixel_out = max_pix;
      end else begin
        word_d.pixel_out = sum[PixW-1:0];
      end
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: design/sample_adaptive_offset_filter.sv
// sample adaptive offset filter, top level: config registers and three-stage pipeline
// an accepted input word passes through the classify, offset and clip stage registers
// throughput: one word per cycle; each stage holds only while its successor is full and stalled
// reset: config registers return to defaults (off, depth 8), all pipeline valid bits clear
// depends on sao_pkg, sao_classify, sao_offset, sao_clip
module sample_adaptive_offset_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [9:0]        cfg_wdata_i,
  // input words
  input  logic              in_valid_i,
  input  sao_pkg::sao_in_t  in_word_i,
  output logic              in_stall_o,
  // result words
  output logic              out_valid_o,
  output sao_pkg::sao_out_t out_word_o,
  input  logic              out_stall_i
);
  import sao_pkg::*;

  sao_cfg_t cfg_q;

  // stage 1 -> 2 and 2 -> 3 links
  logic     cls_valid, cls_stall;
  sao_cls_t cls_word;
  logic     off_valid, off_stall;
  sao_off_t off_word;

  // max pixel value for the current depth, used by the checks below
  logic [PixW-1:0] max_pix;

  // configuration registers; the user must write them only while the pipeline is drained; not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_TYPE:    cfg_q.filter_type    <= cfg_wdata_i[2:0];
        CFG_PIX_DEPTH:      cfg_q.pix_depth      <= cfg_wdata_i[3:0];
        CFG_NEIGHBOR_AVAIL: cfg_q.neighbor_avail <= cfg_wdata_i[7:0];
        CFG_OFFSET_A:       cfg_q.offset_a       <= $signed(cfg_wdata_i[4:0]);
        CFG_OFFSET_B:       cfg_q.offset_b       <= $signed(cfg_wdata_i[4:0]);
        CFG_OFFSET_C:       cfg_q.offset_c       <= $signed(cfg_wdata_i[4:0]);
        CFG_OFFSET_D:       cfg_q.offset_d       <= $signed(cfg_wdata_i[4:0]);
        CFG_BAND_CODE:      cfg_q.band_code      <= cfg_wdata_i;
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  // stage 1: neighbor availability, edge class from the two compares, band index
  sao_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .stall_o (in_stall_o),
    .valid_o (cls_valid),
    .word_o  (cls_word),
    .stall_i (cls_stall)
  );

  // stage 2: pick the offset, band matches resolved with later ones winning
  sao_offset u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (cls_valid),
    .word_i  (cls_word),
    .stall_o (cls_stall),
    .valid_o (off_valid),
    .word_o  (off_word),
    .stall_i (off_stall)
  );

  // stage 3: add and clip; its register is the output register
  sao_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (off_valid),
    .word_i  (off_word),
    .stall_o (off_stall),
    .valid_o (out_valid_o),
    .word_o  (out_word_o),
    .stall_i (out_stall_i)
  );

  assign max_pix = sao_max_pixel(sao_eff_depth(cfg_q.pix_depth));

  // a filtered pixel never leaves the range of the configured depth
  a_clip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.written |-> out_word_o.pixel_out <= max_pix)
    else $error("filtered pixel above clip maximum");

  // the input side only stalls when the whole pipe is backed up behind the output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && off_valid && cls_valid)
    else $error("input stalled while pipeline has room");

  // an accepted word reaches the output if the receiver does not stall on its way through the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("word lost in pipeline");

endmodule

FILE: tb/sample_adaptive_offset_filter_tb.sv
// testbench of the sample adaptive offset filter: directed and random pixel words,
// a predictor of the filtered pixel in a scoreboard class, random idling on both sides
// depends on sao_pkg and sample_adaptive_offset_filter
module sample_adaptive_offset_filter_tb;
  import sao_pkg::*;

  // availability bit positions in neighbor_avail
  localparam int AV_TOP       = 0;
  localparam int AV_DOWN      = 1;
  localparam int AV_LEFT      = 2;
  localparam int AV_RIGHT     = 3;
  localparam int AV_TOPLEFT   = 4;
  localparam int AV_TOPRIGHT  = 5;
  localparam int AV_DOWNLEFT  = 6;
  localparam int AV_DOWNRIGHT = 7;

  // filter type code with no meaning, must act as off
  localparam logic [2:0] FT_SPARE = 3'd7;

  localparam int RAND_PHASES = 20;
  localparam int HOLD_CYCLES = 60;    // long receiver hold-off, fills the pipeline
  localparam int SETTLE      = 6;     // settling wait after the last result, past the three-stage pipeline
  localparam int QUIET_LIMIT = 1000;  // cycles with no handshake or register write before giving up
  localparam int MAX_REPORTS = 200;   // keep the log readable on a broken block

  // tracks config, predicts each filtered pixel and checks results in order
  class sao_tracker;
    sao_out_t               pending_pixels[$];
    int                     errors;
    logic [2:0]             ft;
    logic [3:0]             depth_reg;
    logic [7:0]             avail;
    logic signed [OffW-1:0] ofs[4];
    logic [9:0]             band_code;

    function new();
      errors    = 0;
      ft        = FT_OFF;
      depth_reg = 4'd8;
      avail     = '0;
      band_code = '0;
      foreach (ofs[i]) ofs[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [9:0] v);
      case (idx)
        CFG_FILTER_TYPE:    ft = v[2:0];
        CFG_PIX_DEPTH:      depth_reg = v[3:0];
        CFG_NEIGHBOR_AVAIL: avail = v[7:0];
        CFG_OFFSET_A, CFG_OFFSET_B, CFG_OFFSET_C, CFG_OFFSET_D: begin
          ofs[2'(idx - CFG_OFFSET_A)] = v[OffW-1:0];
        end
        CFG_BAND_CODE:      band_code = v;
        default: ;
      endcase
    endfunction

    // depth saturated into the supported range
    function int pixel_depth();
      int d;
      d = depth_reg;
      if (d < DepthMin) d = DepthMin;
      if (d > PixelBits) d = PixelBits;
      if (d > 15) d = 15;
      return d;
    endfunction

    function int sign_of(int d);
      return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
    endfunction

    // left and right neighbors present where the pixel sits on a column edge
    function bit row_ends_ok(sao_in_t w);
      return (!w.first_col || avail[AV_LEFT]) && (!w.last_col || avail[AV_RIGHT]);
    endfunction

    // diagonal directions; a single-row block must pass both the top and bottom rule
    function bit diag_ok(bit is45, sao_in_t w);
      bit ok;
      if (!w.first_row && !w.last_row) return row_ends_ok(w);
      ok = 1'b1;
      if (w.first_row) begin
        if (is45) begin
          ok &= (avail[AV_TOP] ? (!w.first_col || avail[AV_LEFT]) : w.last_col)
                && (avail[AV_TOPRIGHT] || !w.last_col);
        end else begin
          ok &= (avail[AV_TOPLEFT] || !w.first_col)
                && (avail[AV_TOP] ? (!w.last_col || avail[AV_RIGHT]) : w.first_col);
        end
      end
      if (w.last_row) begin
        if (is45) begin
          ok &= (avail[AV_DOWNLEFT] || !w.first_col)
                && (avail[AV_DOWN] ? (!w.last_col || avail[AV_RIGHT]) : w.first_col);
        end else begin
          ok &= (avail[AV_DOWN] ? (!w.first_col || avail[AV_LEFT]) : w.last_col)
                && (avail[AV_DOWNRIGHT] || !w.last_col);
        end
      end
      return ok;
    endfunction

    function sao_out_t filtered_pixel(sao_in_t w);
      sao_out_t r;
      bit       hit;
      int       eff, top, cpx, ofs_val, cls, band, s1, s2, total;
      eff = pixel_depth();
      top = (1 << eff) - 1;
      if (top > 1023) top = 1023;
      cpx = w.center_pixel;
      case (ft)
        FT_EO_HOR: hit = row_ends_ok(w);
        FT_EO_VER: hit = (!w.first_row || avail[AV_TOP]) && (!w.last_row || avail[AV_DOWN]);
        FT_EO_135: hit = diag_ok(1'b0, w);
        FT_EO_45:  hit = diag_ok(1'b1, w);
        FT_BAND:   hit = 1'b1;
        default:   hit = 1'b0;
      endcase
      ofs_val = 0;
      if (hit && ft == FT_BAND) begin
        // bands above the depth range match nothing; later matches override earlier
        band = cpx >> (eff - 5);
        s1   = band_code[4:0];
        s2   = (s1 + band_code[9:5]) % 32;
        if (band == s1) ofs_val = ofs[0];
        if (band == (s1 + 1) % 32) ofs_val = ofs[1];
        if (band == s2) ofs_val = ofs[2];
        if (band == (s2 + 1) % 32) ofs_val = ofs[3];
      end else if (hit) begin
        cls = sign_of(cpx - int'(w.neighbor_a)) + sign_of(cpx - int'(w.neighbor_b)) + 2;
        case (cls)
          CLS_VALLEY:  ofs_val = ofs[0];
          CLS_CONCAVE: ofs_val = ofs[1];
          CLS_CONVEX:  ofs_val = ofs[2];
          CLS_PEAK:    ofs_val = ofs[3];
          default:     ofs_val = 0;
        endcase
      end
      if (hit) begin
        total = cpx + ofs_val;
        if (total < 0) total = 0;
        if (total > top) total = top;
        r.pixel_out = total[PixW-1:0];
        r.written   = 1'b1;
      end else begin
        r.pixel_out = w.center_pixel;
        r.written   = 1'b0;
      end
      return r;
    endfunction

    function void note_word(sao_in_t w);
      pending_pixels.push_back(filtered_pixel(w));
    endfunction

    function void report(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      end
    endfunction

    function void check_word(sao_out_t got);
      sao_out_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: result word %0d/%0d with nothing expected", $time,
                 got.pixel_out, got.written);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) report("pixel_out", want.pixel_out, got.pixel_out);
      if (got.written !== want.written) report("written", want.written, got.written);
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [9:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  sao_in_t    in_word = '0;
  logic       in_stall;
  logic       out_valid;
  sao_out_t   out_word;
  logic       out_stall = 1'b0;

  // pressure request from the stimulus, served once by the receiver
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int burst_left = 0;

  sao_tracker sb = new();

  sample_adaptive_offset_filter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_word_i   (in_word),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .out_stall_i (out_stall)
  );

  always #6 clk = ~clk;

  // both handshakes are sampled at the edge where they complete
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_word(in_word);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_word(out_word);
    end
  end

  // receiver: segments of no stall, light, alternating and heavy stall,
  // plus one long hold-off once the random part starts
  initial begin : receiver
    int mode;
    int seg;
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 60);
      repeat (seg) begin
        if (hold_req && !hold_done) break;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
        @(posedge clk);
      end
    end
  end

  // ends the run when no handshake or register write happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("sample_adaptive_offset_filter test failed");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // only called while the pipeline is empty
  task automatic load_config(input sao_cfg_t cfg);
    write_reg(CFG_FILTER_TYPE, {7'd0, cfg.filter_type});
    write_reg(CFG_PIX_DEPTH, {6'd0, cfg.pix_depth});
    write_reg(CFG_NEIGHBOR_AVAIL, {2'd0, cfg.neighbor_avail});
    write_reg(CFG_OFFSET_A, {5'd0, cfg.offset_a});
    write_reg(CFG_OFFSET_B, {5'd0, cfg.offset_b});
    write_reg(CFG_OFFSET_C, {5'd0, cfg.offset_c});
    write_reg(CFG_OFFSET_D, {5'd0, cfg.offset_d});
    write_reg(CFG_BAND_CODE, cfg.band_code);
    cfg_we <= 1'b0;
  endtask

  // sender works in bursts; a gap of random length may open each burst
  task automatic send_pixel(input sao_in_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every expected word is back, then let the pipeline settle
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic sao_in_t pix(int cpx, int na, int nb, bit fc, bit lc, bit fr, bit lr);
    sao_in_t w;
    w.center_pixel = PixW'(cpx);
    w.neighbor_a   = PixW'(na);
    w.neighbor_b   = PixW'(nb);
    w.first_col    = fc;
    w.last_col     = lc;
    w.first_row    = fr;
    w.last_row     = lr;
    return w;
  endfunction

  function automatic sao_cfg_t mode_cfg(logic [2:0] ft, logic [3:0] depth, logic [7:0] avail,
                                        int oa, int ob, int oc, int od, logic [9:0] code);
    sao_cfg_t cfg;
    cfg.filter_type    = ft;
    cfg.pix_depth      = depth;
    cfg.neighbor_avail = avail;
    cfg.offset_a       = OffW'(oa);
    cfg.offset_b       = OffW'(ob);
    cfg.offset_c       = OffW'(oc);
    cfg.offset_d       = OffW'(od);
    cfg.band_code      = code;
    return cfg;
  endfunction

  function automatic sao_cfg_t random_cfg();
    sao_cfg_t cfg;
    // mostly real filter modes, sometimes off or an undefined code
    if ($urandom_range(0, 9) == 0) begin
      cfg.filter_type = 3'($urandom);
    end else begin
      cfg.filter_type = 3'($urandom_range(FT_EO_HOR, FT_BAND));
    end
    if ($urandom_range(0, 99) < 85) begin
      cfg.pix_depth = 4'($urandom_range(DepthMin, PixelBits));
    end else begin
      cfg.pix_depth = 4'($urandom);
    end
    cfg.neighbor_avail = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
    cfg.offset_a       = OffW'($urandom);
    cfg.offset_b       = OffW'($urandom);
    cfg.offset_c       = OffW'($urandom);
    cfg.offset_d       = OffW'($urandom);
    cfg.band_code      = 10'($urandom);
    return cfg;
  endfunction

  // neighbor equal to, just above, just below or far from the center
  function automatic logic [PixW-1:0] near_pixel(logic [PixW-1:0] cpx);
    int v;
    case ($urandom_range(0, 3))
      0:       v = cpx;
      1:       v = int'(cpx) + int'($urandom_range(1, 4));
      2:       v = int'(cpx) - int'($urandom_range(1, 4));
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return PixW'(v);
  endfunction

  function automatic sao_in_t random_word();
    sao_in_t    w;
    int         top, shift, band;
    logic [4:0] s1, s2;
    top   = (1 << sb.pixel_depth()) - 1;
    shift = sb.pixel_depth() - 5;
    w.first_col = ($urandom_range(0, 3) == 0);
    w.last_col  = ($urandom_range(0, 3) == 0);
    w.first_row = ($urandom_range(0, 3) == 0);
    w.last_row  = ($urandom_range(0, 3) == 0);
    // mostly inside the depth range, sometimes above it
    if ($urandom_range(0, 9) < 8) begin
      w.center_pixel = PixW'($urandom_range(0, top));
    end else begin
      w.center_pixel = PixW'($urandom);
    end
    // in band mode aim half the words at one of the four offset bands
    if (sb.ft == FT_BAND && $urandom_range(0, 1) == 1) begin
      s1 = sb.band_code[4:0];
      s2 = s1 + sb.band_code[9:5];
      case ($urandom_range(0, 3))
        0:       band = s1;
        1:       band = 5'(s1 + 5'd1);
        2:       band = s2;
        default: band = 5'(s2 + 5'd1);
      endcase
      w.center_pixel = PixW'((band << shift) | $urandom_range(0, (1 << shift) - 1));
    end
    w.neighbor_a = near_pixel(w.center_pixel);
    w.neighbor_b = near_pixel(w.center_pixel);
    return w;
  endfunction

  task automatic directed_checks();
    // reset config: filter off, every word echoed unwritten
    send_pixel(pix(1023, 0, 1023, 1, 1, 1, 1));
    send_pixel(pix(0, 1023, 0, 0, 0, 0, 0));
    drain();

    // undefined filter type behaves as off
    load_config(mode_cfg(FT_SPARE, 4'd8, 8'hff, -16, 15, 15, -16, 10'd0));
    send_pixel(pix(512, 3, 1000, 0, 0, 0, 0));
    drain();

    // horizontal edge, depth 8, only the left neighbor available
    load_config(mode_cfg(FT_EO_HOR, 4'd8, 8'b0000_0100, -16, 15, 15, -16, 10'd0));
    send_pixel(pix(3, 9, 9, 0, 0, 0, 0));          // valley, clipped at zero
    send_pixel(pix(100, 100, 200, 0, 0, 0, 0));    // concave
    send_pixel(pix(1023, 1023, 1023, 0, 0, 0, 0)); // flat, above depth range, clipped
    send_pixel(pix(50, 50, 10, 0, 0, 0, 0));       // convex
    send_pixel(pix(250, 0, 0, 0, 0, 0, 0));        // peak
    send_pixel(pix(20, 30, 30, 1, 0, 0, 0));       // first column, left present
    send_pixel(pix(20, 30, 30, 0, 1, 0, 0));       // last column, right missing
    drain();

    // vertical edge, depth 10, only the top neighbor available
    load_config(mode_cfg(FT_EO_VER, 4'd10, 8'b0000_0001, 15, -16, -16, 15, 10'd0));
    send_pixel(pix(1020, 0, 0, 0, 0, 0, 0));       // peak, clipped at 1023
    send_pixel(pix(500, 600, 600, 0, 0, 0, 1));    // last row, down missing
    send_pixel(pix(0, 1023, 1023, 0, 0, 1, 0));    // first row, valley
    drain();

    // 135 diagonal: top, left and down-right available
    load_config(mode_cfg(FT_EO_135, 4'd9, 8'b1000_0101, 7, -3, 4, -9, 10'd0));
    send_pixel(pix(40, 50, 60, 0, 0, 1, 1));       // single-row block fails bottom rule
    send_pixel(pix(40, 50, 60, 0, 1, 1, 0));       // first row, last column, no right
    send_pixel(pix(40, 50, 60, 1, 0, 0, 0));       // middle row, first column
    drain();

    // 45 diagonal: down, right, top-right and down-left available
    load_config(mode_cfg(FT_EO_45, 4'd9, 8'b0110_1010, 7, -3, 4, -9, 10'd0));
    send_pixel(pix(70, 60, 50, 1, 0, 0, 1));       // last row, first column
    send_pixel(pix(70, 60, 80, 0, 1, 1, 0));       // first row corner, no top
    send_pixel(pix(70, 80, 90, 1, 0, 1, 0));       // first row, first column, no top
    drain();

    // band mode, depth above range saturates to 10; start band 31, both starts equal
    load_config(mode_cfg(FT_BAND, 4'd15, 8'h00, -16, 15, 7, -5, 10'd31));
    send_pixel(pix(997, 0, 0, 1, 1, 1, 1));        // band 31, second start overrides
    send_pixel(pix(5, 0, 0, 0, 0, 0, 0));          // wrapped band 0, last offset wins
    send_pixel(pix(100, 0, 0, 0, 0, 0, 0));        // band with no offset
    drain();

    // band mode, depth below range saturates to 8; second start just below the first
    load_config(mode_cfg(FT_BAND, 4'd0, 8'hff, 15, -16, -16, 9, {5'd31, 5'd2}));
    send_pixel(pix(17, 0, 0, 0, 0, 0, 0));         // first start band, overlap goes to d
    send_pixel(pix(8, 0, 0, 0, 0, 0, 0));          // second start band, clipped at zero
    send_pixel(pix(1023, 0, 0, 0, 0, 0, 0));       // band beyond 31, clipped to 255
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    hold_req = 1'b1;
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_config(random_cfg());
      repeat ($urandom_range(25, 45)) send_pixel(random_word());
      drain();
    end
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("sample_adaptive_offset_filter test passed");
    end else begin
      $display("sample_adaptive_offset_filter test failed");
    end
    $finish;
  end

endmodule

FILE: sample_adaptive_offset_filter.f
design/sao_pkg.sv
design/sao_classify.sv
design/sao_offset.sv
design/sao_clip.sv
design/sample_adaptive_offset_filter.sv
tb/sample_adaptive_offset_filter_tb.sv
